/* rtl/core/sbf_pkg.sv */
// Shared types and constants for the sample byte framer.
package sbf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int BYTE_W   = 8;

    // Request command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes
    localparam int              CFG_IDX_W         = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_A_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_B_EN = 2'd2;

    // Port codes
    localparam logic PORT_A = 1'b0;
    localparam logic PORT_B = 1'b1;

    typedef struct packed {
        logic stream_en;
        logic port_a_en;
        logic port_b_en;
    } sbf_cfg_t;

    typedef struct packed {
        logic clearing;
    } sbf_stat_t;

    // Queued command: a tick, or four framed bytes (index 0 is written first)
    typedef struct packed {
        logic                        tick;
        logic [3:0][BYTE_W-1:0]      bytes;
    } sbf_cmd_t;

endpackage

/* rtl/core/sbf_if.sv */
// Request and result channel interfaces of the sample byte framer.
interface sbf_req_if
    import sbf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_first;
    logic [SAMPLE_W-1:0] sample_second;

    modport source (output valid, cmd, sample_first, sample_second, input ready);
    modport sink   (input valid, cmd, sample_first, sample_second, output ready);
endinterface

interface sbf_res_if
    import sbf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              port_select;
    logic [BYTE_W-1:0] byte_value;
    logic              last_of_run;

    modport source (output valid, port_select, byte_value, last_of_run, input ready);
    modport sink   (input valid, port_select, byte_value, last_of_run, output ready);
endinterface

/* rtl/core/sample_byte_framer_ring_drain.sv */
// Top level of the sample byte framer with ring-buffer drain.
//
//  channel   direction  carries
//  req       in         cmd, sample_first, sample_second
//  res       out        port_select, byte_value, last_of_run
//  cfg_*     in         stream_enable, port_a_enable, port_b_enable writes
//
// In the back end a sample pair pops the queue, then makes four byte writes.
// A tick pops the queue, then drains up to eight bytes: read issue, output load for each.
// After reset a clearing pass writes BUFFER_DEPTH zeros, one per cycle; req.ready stays low.
// A two-entry queue lets requests land while the back end works or res is stalled.
module sample_byte_framer_ring_drain
    import sbf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    sbf_req_if.sink              req,
    sbf_res_if.source            res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [0:0]           cfg_data
);

    sbf_cfg_t  cfg_reg;
    sbf_cfg_t  cfg_next;
    sbf_stat_t stat;
    sbf_cmd_t  push_data;
    sbf_cmd_t  pop_data;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_nonempty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_STREAM_EN: cfg_next.stream_en = cfg_data[0];
                CFG_PORT_A_EN: cfg_next.port_a_en = cfg_data[0];
                CFG_PORT_B_EN: cfg_next.port_b_en = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sbf_front u_front (
        .req    (req),
        .stat   (stat),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_data)
    );

    sbf_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (pop_data)
    );

    sbf_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .stat       (stat),
        .q_nonempty (q_nonempty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .res        (res)
    );

    // No request taken and no result shown during the clearing pass
    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !req.ready)
        else $error("request accepted during clearing pass");

    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !res.valid)
        else $error("result shown during clearing pass");

    // A run ends cleanly: nothing follows right after its final byte is taken
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last_of_run) |=> !res.valid)
        else $error("result follows final byte of a run without a gap");

    // The queue is never popped when empty nor pushed when full
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && !q_nonempty) && !(q_push && q_full))
        else $error("command queue overflow or underflow");

endmodule

/* rtl/core/sbf_front.sv */
// Front end: accepts requests, classifies them and frames sample pairs into bytes.
module sbf_front
    import sbf_pkg::*;
(
    sbf_req_if.sink  req,
    input  sbf_stat_t stat,
    input  logic      q_full,
    output logic      q_push,
    output sbf_cmd_t  q_data
);

    function automatic logic [1:0][BYTE_W-1:0] frame(input logic [SAMPLE_W-1:0] s);
        logic [1:0][BYTE_W-1:0] b;
        b[0] = {1'b1, 1'b0, s[11:6]};
        b[1] = {s[5:0], 2'b01};
        return b;
    endfunction

    logic [1:0][BYTE_W-1:0] first_bytes;
    logic [1:0][BYTE_W-1:0] second_bytes;

    assign first_bytes  = frame(req.sample_first);
    assign second_bytes = frame(req.sample_second);

    // Hold off requests while the queue is full or the store is being cleared
    assign req.ready = !q_full && !stat.clearing;
    assign q_push    = req.valid && req.ready;

    always_comb
    begin
        q_data.tick     = (req.cmd == CMD_TICK);
        q_data.bytes[0] = first_bytes[0];
        q_data.bytes[1] = first_bytes[1];
        q_data.bytes[2] = second_bytes[0];
        q_data.bytes[3] = second_bytes[1];
    end

endmodule

/* rtl/core/sbf_cmd_fifo.sv */
// Two-entry command queue between front and back.
module sbf_cmd_fifo
    import sbf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  sbf_cmd_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     nonempty,
    output sbf_cmd_t pop_data
);

    sbf_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/sbf_back.sv */
// Back end: ring store, clearing pass, byte writes and tick drains.
module sbf_back
    import sbf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sbf_cfg_t   cfg,
    output sbf_stat_t  stat,
    input  logic       q_nonempty,
    input  sbf_cmd_t   q_data,
    output logic       q_pop,
    sbf_res_if.source  res
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(BUFFER_DEPTH - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [PTR_W-1:0]       wp_reg;
    logic [PTR_W-1:0]       wp_next;
    logic [PTR_W-1:0]       rp_reg;
    logic [PTR_W-1:0]       rp_next;
    logic [2:0]             cnt_reg;
    logic [2:0]             cnt_next;
    logic                   run_a_reg;
    logic                   run_a_next;
    logic                   run_b_reg;
    logic                   run_b_next;
    logic [3:0][BYTE_W-1:0] bytes_reg;
    logic [3:0][BYTE_W-1:0] bytes_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_port_reg;
    logic                   out_port_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [BYTE_W-1:0]      out_byte_next;
    logic                   out_last_reg;
    logic                   out_last_next;

    logic                   mem_we;
    logic [BYTE_W-1:0]      mem_wdata;
    logic                   out_free;
    logic                   run_go;
    logic                   at_last;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       rp_inc;

    assign stat.clearing   = (state_reg == ST_CLEAR);
    assign res.valid       = out_valid_reg;
    assign res.port_select = out_port_reg;
    assign res.byte_value  = out_byte_reg;
    assign res.last_of_run = out_last_reg;

    assign wp_inc   = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == LAST_ADDR) ? '0 : rp_reg + 1'b1;
    assign out_free = !out_valid_reg || res.ready;
    assign run_go   = cfg.stream_en && (wp_reg != rp_reg) && (cfg.port_a_en || cfg.port_b_en);
    assign at_last  = (run_a_reg && run_b_reg) ? (cnt_reg == 3'd7) : (cnt_reg == 3'd3);
    assign q_pop    = (state_reg == ST_IDLE) && q_nonempty;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        cnt_next       = cnt_reg;
        run_a_next     = run_a_reg;
        run_b_next     = run_b_reg;
        bytes_next     = bytes_reg;
        out_port_next  = out_port_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !res.ready;
        mem_we         = 1'b0;
        mem_wdata      = bytes_reg[cnt_reg[1:0]];

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the store with zeros; the write pointer wraps back to zero
                mem_we    = 1'b1;
                mem_wdata = '0;
                wp_next   = wp_inc;
                if (wp_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_nonempty)
                begin
                    cnt_next = 3'd0;
                    if (!q_data.tick)
                    begin
                        bytes_next = q_data.bytes;
                        state_next = ST_WRITE;
                    end
                    else if (run_go)
                    begin
                        run_a_next = cfg.port_a_en;
                        run_b_next = cfg.port_b_en;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_we   = 1'b1;
                wp_next  = wp_inc;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ISSUE:
            begin
                // Read at the current pointer; go on only once the output slot frees up
                if (out_free)
                begin
                    rp_next    = rp_inc;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                out_valid_next = 1'b1;
                out_byte_next  = rdata_reg;
                out_port_next  = run_a_reg ? (cnt_reg[2] ? PORT_B : PORT_A) : PORT_B;
                out_last_next  = at_last;
                cnt_next       = cnt_reg + 3'd1;
                state_next     = at_last ? ST_IDLE : ST_ISSUE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= 3'd0;
            run_a_reg     <= 1'b0;
            run_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            cnt_reg       <= cnt_next;
            run_a_reg     <= run_a_next;
            run_b_reg     <= run_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg    <= bytes_next;
        out_port_reg <= out_port_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= mem_wdata;
        end
        rdata_reg <= mem[rp_reg];
    end

endmodule

/* test/sample_byte_framer_ring_drain_tb.sv */
// Self-checking testbench for the sample byte framer with ring-buffer drain.
module sample_byte_framer_ring_drain_tb;
    import sbf_pkg::*;

    localparam int RING_DEPTH     = 256;
    localparam int LONG_HOLD      = 150;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic              port_select;
        logic [BYTE_W-1:0] byte_value;
        logic              last_of_run;
    } drained_byte_t;

    class ring_drain_predictor;
        logic [BYTE_W-1:0] ring [RING_DEPTH];
        int unsigned       wr_ptr;
        int unsigned       rd_ptr;
        logic              stream_en;
        logic              port_a_en;
        logic              port_b_en;
        drained_byte_t     expected_bytes [$];
        int                mismatch_count;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            wr_ptr         = 0;
            rd_ptr         = 0;
            stream_en      = 1'b0;
            port_a_en      = 1'b0;
            port_b_en      = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic val);
            case (idx)
                CFG_STREAM_EN: stream_en = val;
                CFG_PORT_A_EN: port_a_en = val;
                CFG_PORT_B_EN: port_b_en = val;
                default: ;
            endcase
        endfunction

        function void frame_sample(logic [SAMPLE_W-1:0] s);
            ring[wr_ptr] = {2'b10, s[11:6]};
            wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
            ring[wr_ptr] = {s[5:0], 2'b01};
            wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
        endfunction

        // Read four bytes for one port, no empty check between them
        function void drain_run(logic port, logic final_run);
            drained_byte_t b;
            for (int i = 0; i < 4; i++)
            begin
                b.port_select = port;
                b.byte_value  = ring[rd_ptr];
                b.last_of_run = final_run && (i == 3);
                expected_bytes.push_back(b);
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
        endfunction

        function void note_request(logic cmd, logic [SAMPLE_W-1:0] first,
                                   logic [SAMPLE_W-1:0] second);
            if (cmd == CMD_SAMPLE)
            begin
                frame_sample(first);
                frame_sample(second);
            end
            else if (stream_en && wr_ptr != rd_ptr)
            begin
                if (port_a_en)
                    drain_run(PORT_A, !port_b_en);
                if (port_b_en)
                    drain_run(PORT_B, 1'b1);
            end
        endfunction

        function void check_byte(logic port, logic [BYTE_W-1:0] value, logic last);
            drained_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected byte: port %0d byte %02h last %0d",
                             port, value, last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (want.port_select !== port || want.byte_value !== value
                    || want.last_of_run !== last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"byte mismatch: expected port %0d byte %02h last %0d,",
                                  " got port %0d byte %02h last %0d"},
                                 want.port_select, want.byte_value, want.last_of_run,
                                 port, value, last);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [0:0]           cfg_data;
    logic                 idling_on    = 1'b1;
    logic                 hold_results = 1'b0;
    int                   quiet_cycles = 0;

    ring_drain_predictor predictor = new();

    sbf_req_if req_ch();
    sbf_res_if res_ch();

    sample_byte_framer_ring_drain #(
        .BUFFER_DEPTH(RING_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            predictor.note_request(req_ch.cmd, req_ch.sample_first, req_ch.sample_second);
        if (rst_n && res_ch.valid && res_ch.ready)
            predictor.check_byte(res_ch.port_select, res_ch.byte_value, res_ch.last_of_run);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sample_byte_framer_ring_drain regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_results)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] first,
                                input logic [SAMPLE_W-1:0] second);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.sample_first  <= first;
        req_ch.sample_second <= second;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_random(input logic cmd);
        send_request(cmd, SAMPLE_W'($urandom_range(0, 4095)),
                     SAMPLE_W'($urandom_range(0, 4095)));
    endtask

    task automatic run_random(input int count, input int tick_pct);
        for (int n = 0; n < count; n++)
            send_random(($urandom_range(1, 100) <= tick_pct) ? CMD_TICK : CMD_SAMPLE);
    endtask

    // Drop valid, drain every expected byte, then let the back end go quiet
    task automatic finish_phase();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (predictor.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic stream, input logic port_a, input logic port_b);
        logic [CFG_IDX_W-1:0] idx [4];
        logic                 val [4];
        idx = '{CFG_STREAM_EN, CFG_PORT_A_EN, CFG_PORT_B_EN, CFG_IDX_SPARE};
        val = '{stream, port_a, port_b, 1'($urandom_range(0, 1))};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            predictor.write_register(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int pairs;
        int sent;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_STREAM_EN;
        cfg_data             = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_SAMPLE;
        req_ch.sample_first  = '0;
        req_ch.sample_second = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Streaming off after reset: ticks drop
        send_random(CMD_TICK);
        send_request(CMD_SAMPLE, 12'h000, 12'hFFF);
        send_request(CMD_SAMPLE, 12'h03F, 12'hFC0);
        send_random(CMD_TICK);
        finish_phase();

        set_config(1'b1, 1'b1, 1'b0);
        send_random(CMD_TICK);
        send_request(CMD_SAMPLE, 12'hAAA, 12'h555);
        finish_phase();

        set_config(1'b1, 1'b0, 1'b1);
        send_random(CMD_TICK);
        send_random(CMD_TICK);
        finish_phase();

        // Empty store, then underflow into cleared bytes
        set_config(1'b1, 1'b1, 1'b1);
        send_random(CMD_TICK);
        send_request(CMD_SAMPLE, 12'h800, 12'h001);
        send_random(CMD_TICK);
        send_random(CMD_TICK);
        finish_phase();

        set_config(1'b1, 1'b0, 1'b0);
        send_random(CMD_SAMPLE);
        send_random(CMD_TICK);
        finish_phase();

        set_config(1'b0, 1'b1, 1'b1);
        send_random(CMD_TICK);
        finish_phase();

        // Fill with streaming off until the write pointer lands on the read pointer
        set_config(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        pairs = ((predictor.rd_ptr + RING_DEPTH - predictor.wr_ptr) % RING_DEPTH) / 4;
        if (pairs < 32)
            pairs += RING_DEPTH / 4;
        sent = 0;
        while (sent < pairs)
        begin
            if ($urandom_range(0, 9) == 0)
                send_random(CMD_TICK);
            else
            begin
                send_random(CMD_SAMPLE);
                sent++;
            end
        end
        finish_phase();

        // Lapped store looks empty; then stall results so the queue backs up
        set_config(1'b1, 1'b1, 1'b1);
        send_random(CMD_TICK);
        hold_results = 1'b1;
        run_random(50, 35);
        finish_phase();

        set_config(1'b1, 1'b1, 1'b0);
        run_random(40, 30);
        finish_phase();

        idling_on = 1'b0;
        set_config(1'b1, 1'b0, 1'b1);
        run_random(40, 30);
        finish_phase();

        if (predictor.mismatch_count == 0 && predictor.expected_bytes.size() == 0)
            $display("sample_byte_framer_ring_drain regression: pass");
        else
            $display("sample_byte_framer_ring_drain regression: fail");
        $finish;
    end

endmodule

/* sample_byte_framer_ring_drain.f */
rtl/core/sbf_pkg.sv
rtl/core/sbf_if.sv
rtl/core/sbf_front.sv
rtl/core/sbf_cmd_fifo.sv
rtl/core/sbf_back.sv
rtl/core/sample_byte_framer_ring_drain.sv
test/sample_byte_framer_ring_drain_tb.sv
